// ----- design/gll_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gll_pkg: shared types and constants for the lattice step block
// Field formats, command and op codes, register indexes, and the request
// that the front passes to the back.
// ----------------------------------------------------------------------------
package gll_pkg;

  // field formats
  localparam int VALUE_W   = 32;
  localparam int FRAC      = 24;   // fraction bits of a field value
  localparam int COEF_FRAC = 12;   // fraction bits of laplace_coef
  localparam int DT_FRAC   = 24;   // fraction bits of time_step
  localparam int CFG_W     = 24;
  localparam int SITES_W   = 11;
  localparam int IDX_W     = 10;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 2;

  // input commands
  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STEP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAPLACE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SITES     = 2'd2;

  // configuration reset values
  localparam logic [CFG_W-1:0]   TIME_STEP_RST = 24'd134218;
  localparam logic [CFG_W-1:0]   LAPLACE_RST   = 24'd409600;
  localparam logic [SITES_W-1:0] SITES_RST     = 11'd1000;

  // result kinds
  localparam logic KIND_AVG  = 1'b0;
  localparam logic KIND_SITE = 1'b1;

  // classified operation
  typedef enum logic [1:0] {
    OP_LOAD,
    OP_STEP,
    OP_READ,
    OP_READ_ZERO
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic [IDX_W-1:0]          idx;
    logic signed [VALUE_W-1:0] value;
    logic signed [VALUE_W-1:0] drive;
  } req_t;

endpackage

// ----- design/gll_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gll_front: request intake and classification
// Classifies each accepted request and holds it in a two-entry queue
// until the back end takes it.
// ----------------------------------------------------------------------------
module gll_front #(
  parameter int MAX_SITES = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [gll_pkg::CMD_W-1:0]            cmd,
  input  logic [gll_pkg::IDX_W-1:0]            site_index,
  input  logic signed [gll_pkg::VALUE_W-1:0]   site_value,
  input  logic signed [gll_pkg::VALUE_W-1:0]   drive_c,
  input  logic                                 pop,
  output logic                                 busy,
  output logic                                 q_valid,
  output gll_pkg::req_t                        q_head
);

  gll_pkg::req_t req;
  logic          keep;
  logic          push;
  logic          in_range;

  gll_pkg::req_t ent [2];
  logic [1:0]    count;
  logic          wp;
  logic          rp;

  // classify: unknown commands and out-of-range loads are dropped
  always_comb begin
    in_range  = 32'(site_index) < MAX_SITES;
    req.idx   = site_index;
    req.value = site_value;
    req.drive = drive_c;
    req.op    = gll_pkg::OP_LOAD;
    keep      = 1'b0;
    unique case (cmd)
      gll_pkg::CMD_LOAD: begin
        req.op = gll_pkg::OP_LOAD;
        keep   = in_range;
      end
      gll_pkg::CMD_STEP: begin
        req.op = gll_pkg::OP_STEP;
        keep   = 1'b1;
      end
      gll_pkg::CMD_READ: begin
        req.op = in_range ? gll_pkg::OP_READ : gll_pkg::OP_READ_ZERO;
        keep   = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign busy    = (count == 2'd2);
  assign push    = start && !busy && keep;
  assign q_valid = (count != 2'd0);
  assign q_head  = ent[rp];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent[wp] <= req;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wp    <= 1'b0;
      rp    <= 1'b0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

// ----- design/gll_update.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gll_update: five-stage site update pipeline
// new = sat32(u + dt*(coef*(r+l-2u) - u^3 + C*u)), every product floored.
// ----------------------------------------------------------------------------
module gll_update (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_v,
  input  logic signed [gll_pkg::VALUE_W-1:0]  left,
  input  logic signed [gll_pkg::VALUE_W-1:0]  cur,
  input  logic signed [gll_pkg::VALUE_W-1:0]  right,
  input  logic signed [gll_pkg::VALUE_W-1:0]  drive,
  input  logic [gll_pkg::CFG_W-1:0]           dt,
  input  logic [gll_pkg::CFG_W-1:0]           coef,
  output logic                                out_v,
  output logic signed [gll_pkg::VALUE_W-1:0]  out_val,
  output logic                                pipe_busy
);

  logic               v1, v2, v3, v4;
  logic signed [33:0] lap_raw;
  logic signed [58:0] p_lap;
  logic signed [63:0] p_sq;
  logic signed [63:0] p_cu;
  logic signed [31:0] u1, u2, u3, u4;
  logic signed [46:0] lap2;
  logic signed [39:0] sq;
  logic signed [71:0] p_cube;
  logic signed [39:0] cu2;
  logic signed [49:0] rate3;
  logic signed [74:0] p_d;
  logic signed [51:0] nsum;

  assign lap_raw = 34'(left) + 34'(right) - (34'(cur) <<< 1);
  assign sq      = 40'(p_sq >>> gll_pkg::FRAC);
  assign nsum    = 52'(u4) + 52'(p_d >>> gll_pkg::DT_FRAC);

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      v4    <= 1'b0;
      out_v <= 1'b0;
    end else begin
      v1    <= in_v;
      v2    <= v1;
      v3    <= v2;
      v4    <= v3;
      out_v <= v4;
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    // stage 1: laplacian, square and drive products
    p_lap <= lap_raw * $signed({1'b0, coef});
    p_sq  <= cur * cur;
    p_cu  <= drive * cur;
    u1    <= cur;
    // stage 2: cube product
    lap2   <= 47'(p_lap >>> gll_pkg::COEF_FRAC);
    p_cube <= sq * u1;
    cu2    <= 40'(p_cu >>> gll_pkg::FRAC);
    u2     <= u1;
    // stage 3: rate
    rate3 <= 50'(lap2) - 50'(p_cube >>> gll_pkg::FRAC) + 50'(cu2);
    u3    <= u2;
    // stage 4: time step product
    p_d <= rate3 * $signed({1'b0, dt});
    u4  <= u3;
    // stage 5: add and saturate
    if (nsum > 52'sd2147483647)       out_val <= 32'sh7fffffff;
    else if (nsum < -52'sd2147483648) out_val <= 32'sh80000000;
    else                              out_val <= nsum[31:0];
  end

  assign pipe_busy = v1 || v2 || v3 || v4 || out_v;

endmodule

// ----- design/gll_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gll_back: lattice memory and step sequencer
// Executes loads and reads, sweeps the ring through the update pipeline,
// then divides the sum of new values by the ring length.
// ----------------------------------------------------------------------------
module gll_back #(
  parameter int MAX_SITES = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  input  gll_pkg::req_t                       q_head,
  output logic                                pop,
  input  logic [gll_pkg::CFG_W-1:0]           dt,
  input  logic [gll_pkg::CFG_W-1:0]           coef,
  input  logic [gll_pkg::SITES_W-1:0]         sites,
  output logic                                done,
  output logic                                res_kind,
  output logic signed [gll_pkg::VALUE_W-1:0]  res_value
);

  localparam int AW  = $clog2(MAX_SITES);
  localparam int CW  = $clog2(MAX_SITES + 1);
  localparam int SW  = gll_pkg::VALUE_W + CW;
  localparam int DCW = $clog2(SW + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RDOUT = 3'd1;
  localparam logic [2:0] ST_ISSUE = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0] state;

  // lattice memory
  logic signed [gll_pkg::VALUE_W-1:0] mem [MAX_SITES];
  logic                               we;
  logic [AW-1:0]                      wa;
  logic signed [gll_pkg::VALUE_W-1:0] wd;
  logic [AW-1:0]                      ra;
  logic signed [gll_pkg::VALUE_W-1:0] rd_data;

  // sweep control
  logic [CW-1:0]                      n;
  logic [CW-1:0]                      n_calc;
  logic [CW-1:0]                      k;
  logic [AW-1:0]                      iss_addr;
  logic                               dv;
  logic                               dlast;
  logic                               syn_v;
  logic [1:0]                         ecnt;
  logic                               elem_v;
  logic signed [gll_pkg::VALUE_W-1:0] elem;
  logic signed [gll_pkg::VALUE_W-1:0] wl;
  logic signed [gll_pkg::VALUE_W-1:0] wc;
  logic signed [gll_pkg::VALUE_W-1:0] first_old;
  logic signed [gll_pkg::VALUE_W-1:0] drive;
  logic [AW-1:0]                      widx;
  logic signed [SW-1:0]               sum;
  logic                               launch;

  // update pipeline outputs
  logic                               upd_v;
  logic signed [gll_pkg::VALUE_W-1:0] upd_val;
  logic                               upd_busy;

  // divider
  logic [SW-1:0]                      dq;
  logic [CW:0]                        rem;
  logic [CW:0]                        rem_sh;
  logic                               qbit;
  logic [DCW-1:0]                     dcnt;
  logic                               neg;
  logic [SW-1:0]                      quot_s;

  // ring length clamp
  always_comb begin
    int s;
    s = int'(sites);
    if (s < 3)         s = 3;
    if (s > MAX_SITES) s = MAX_SITES;
    n_calc = CW'(s);
  end

  assign pop = (state == ST_IDLE) && q_valid;

  // read order: n-1, 0, 1, ..., n-1
  assign iss_addr = (k == '0) ? AW'(n - 1'b1) : AW'(k - 1'b1);
  assign ra       = (state == ST_ISSUE) ? iss_addr : AW'(q_head.idx);

  // memory write select
  always_comb begin
    we = 1'b0;
    wa = widx;
    wd = upd_val;
    if (upd_v) begin
      we = 1'b1;
    end else if (pop && q_head.op == gll_pkg::OP_LOAD) begin
      we = 1'b1;
      wa = AW'(q_head.idx);
      wd = q_head.value;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_data <= mem[ra];
  end

  // element stream: memory data, then the saved first value
  assign elem_v = dv || syn_v;
  assign elem   = syn_v ? first_old : rd_data;
  assign launch = elem_v && (ecnt == 2'd2);

  gll_update u_update (
    .clk       (clk),
    .rst       (rst),
    .in_v      (launch),
    .left      (wl),
    .cur       (wc),
    .right     (elem),
    .drive     (drive),
    .dt        (dt),
    .coef      (coef),
    .out_v     (upd_v),
    .out_val   (upd_val),
    .pipe_busy (upd_busy)
  );

  // restoring divide step
  always_comb begin
    rem_sh = {rem[CW-1:0], dq[SW-1]};
    qbit   = rem_sh >= (CW+1)'(n);
  end

  assign quot_s = neg ? (~dq + 1'b1) : dq;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      dv    <= 1'b0;
      dlast <= 1'b0;
      syn_v <= 1'b0;
      ecnt  <= 2'd0;
      k     <= '0;
      dcnt  <= '0;
    end else begin
      done  <= 1'b0;
      dv    <= (state == ST_ISSUE);
      dlast <= (state == ST_ISSUE) && (k == n);
      syn_v <= dv && dlast;
      if (elem_v && ecnt != 2'd2) ecnt <= ecnt + 2'd1;
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            unique case (q_head.op)
              gll_pkg::OP_LOAD:      state <= ST_IDLE;
              gll_pkg::OP_READ:      state <= ST_RDOUT;
              gll_pkg::OP_READ_ZERO: done  <= 1'b1;
              gll_pkg::OP_STEP: begin
                state <= ST_ISSUE;
                k     <= '0;
                ecnt  <= 2'd0;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_RDOUT: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        ST_ISSUE: begin
          k <= k + 1'b1;
          if (k == n) state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (!dv && !syn_v && !upd_busy) begin
            state <= ST_DIV;
            dcnt  <= '0;
          end
        end
        ST_DIV: begin
          dcnt <= dcnt + 1'b1;
          if (dcnt == DCW'(SW - 1)) state <= ST_EMIT;
        end
        ST_EMIT: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (pop && q_head.op == gll_pkg::OP_STEP) begin
      n     <= n_calc;
      drive <= q_head.drive;
      widx  <= '0;
      sum   <= '0;
    end
    // sliding window over the element stream
    if (elem_v) begin
      unique case (ecnt)
        2'd0: wl <= elem;
        2'd1: begin
          wc        <= elem;
          first_old <= elem;
        end
        default: begin
          wl <= wc;
          wc <= elem;
        end
      endcase
    end
    if (upd_v) begin
      widx <= widx + 1'b1;
      sum  <= sum + SW'(upd_val);
    end
    // divider
    if (state == ST_WAIT) begin
      neg <= sum < 0;
      dq  <= (sum < 0) ? SW'(-sum) : SW'(sum);
      rem <= '0;
    end else if (state == ST_DIV) begin
      rem <= qbit ? (rem_sh - (CW+1)'(n)) : rem_sh;
      dq  <= {dq[SW-2:0], qbit};
    end
    // result registers
    if (state == ST_RDOUT) begin
      res_kind  <= gll_pkg::KIND_SITE;
      res_value <= rd_data;
    end else if (pop && q_head.op == gll_pkg::OP_READ_ZERO) begin
      res_kind  <= gll_pkg::KIND_SITE;
      res_value <= '0;
    end else if (state == ST_EMIT) begin
      res_kind  <= gll_pkg::KIND_AVG;
      res_value <= quot_s[gll_pkg::VALUE_W-1:0];
    end
  end

endmodule

// ----- design/ginzburg_landau_lattice_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ginzburg_landau_lattice_step: periodic 1D relaxation lattice
// Load, read and explicit Euler step of a ring of Q8.24 field values.
// ----------------------------------------------------------------------------
// A load writes the lattice when the back end takes it and gives no result.
// A read answers through the memory read register and the RDOUT state; a read
// of an index beyond the lattice answers zero in the cycle after the back end
// takes it. A step sweeps the ring through a five-stage update pipeline fed by
// one memory read per cycle (n + 1 reads), waits for the pipeline to drain,
// then divides the sum by the ring length one quotient bit a cycle for each bit
// of the 32 + clog2(MAX_SITES+1)-bit sum. Requests queue two deep in front of
// the back end; busy is high while that queue is full. Results appear for one
// cycle on done and the receiver cannot stall them.
// ----------------------------------------------------------------------------
module ginzburg_landau_lattice_step #(
  parameter int MAX_SITES = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [gll_pkg::CMD_W-1:0]           cmd,
  input  logic [gll_pkg::IDX_W-1:0]           site_index,
  input  logic signed [gll_pkg::VALUE_W-1:0]  site_value,
  input  logic signed [gll_pkg::VALUE_W-1:0]  drive_c,
  input  logic                                cfg_we,
  input  logic [gll_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gll_pkg::CFG_W-1:0]           cfg_data,
  output logic                                done,
  output logic                                result_kind,
  output logic signed [gll_pkg::VALUE_W-1:0]  result_value
);

  logic [gll_pkg::CFG_W-1:0]   time_step;
  logic [gll_pkg::CFG_W-1:0]   laplace_coef;
  logic [gll_pkg::SITES_W-1:0] sites_in_use;

  logic          q_valid;
  logic          pop;
  gll_pkg::req_t q_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step    <= gll_pkg::TIME_STEP_RST;
      laplace_coef <= gll_pkg::LAPLACE_RST;
      sites_in_use <= gll_pkg::SITES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gll_pkg::CFG_TIME_STEP: time_step    <= cfg_data;
        gll_pkg::CFG_LAPLACE:   laplace_coef <= cfg_data;
        gll_pkg::CFG_SITES:     sites_in_use <= cfg_data[gll_pkg::SITES_W-1:0];
        default:                time_step    <= time_step;
      endcase
    end
  end

  gll_front #(
    .MAX_SITES (MAX_SITES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .cmd        (cmd),
    .site_index (site_index),
    .site_value (site_value),
    .drive_c    (drive_c),
    .pop        (pop),
    .busy       (busy),
    .q_valid    (q_valid),
    .q_head     (q_head)
  );

  gll_back #(
    .MAX_SITES (MAX_SITES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (pop),
    .dt        (time_step),
    .coef      (laplace_coef),
    .sites     (sites_in_use),
    .done      (done),
    .res_kind  (result_kind),
    .res_value (result_value)
  );

endmodule

// ----- design/gll_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gll_checker: port-level checks for the lattice step block
// Watches reset, queue fullness and average result timing.
// ----------------------------------------------------------------------------
module gll_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic result_kind
);

  // reset leaves no result pending and the queue empty
  a_reset_quiet: assert property (@(posedge clk) rst |=> (!done && !busy))
    else $error("result or busy right after reset");

  // the queue only fills through a new request
  a_busy_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

  // without a request, a queue that has room keeps room
  a_busy_hold: assert property (@(posedge clk) disable iff (rst)
    (!busy && !start) |=> !busy)
    else $error("busy rose while idle");

  // an average follows the divide, never another result
  a_avg_alone: assert property (@(posedge clk) disable iff (rst)
    (done && result_kind == gll_pkg::KIND_AVG) |-> !$past(done))
    else $error("average result back to back with another result");

endmodule

bind ginzburg_landau_lattice_step gll_checker u_gll_checker (.*);
